// File: hdl/rotate_xor_string_hash_index_defines.svh
// ----------------------------------------------------------------------------
// rotate_xor_string_hash_index_defines.svh
// assertion macros shared by the hash index checker
// ----------------------------------------------------------------------------
`ifndef ROTATE_XOR_STRING_HASH_INDEX_DEFINES_SVH
`define ROTATE_XOR_STRING_HASH_INDEX_DEFINES_SVH

// antecedent and consequent in the same cycle
`define RXH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define RXH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rxh_pkg.sv
// ----------------------------------------------------------------------------
// rxh_pkg
// widths, constants, types and the byte mixing function of the hash index
// ----------------------------------------------------------------------------
`default_nettype none

package rxh_pkg;

    localparam int unsigned HASH_W          = 32;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned ROT_LEFT        = 5;
    localparam int unsigned ROT_RIGHT       = HASH_W - ROT_LEFT;
    localparam logic [HASH_W-1:0] TABLE_SIZE_RESET = HASH_W'(1024);

    // handshake status of the shared remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // rotate left by five and fold the byte into the low bits
    function automatic logic [HASH_W-1:0] hash_mix(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] rotated;
        rotated = {h[ROT_RIGHT-1:0], h[HASH_W-1:ROT_RIGHT]};
        return rotated ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    endfunction

endpackage

`default_nettype wire

// File: hdl/rxh_mod_unit.sv
// ----------------------------------------------------------------------------
// rxh_mod_unit
// iterative restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rxh_mod_unit #(
    parameter int unsigned W = rxh_pkg::HASH_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_dividend,
    input  logic [W-1:0]         i_divisor,
    output logic [W-1:0]         o_remainder,
    output rxh_pkg::t_div_status o_status
);
    import rxh_pkg::*;

    localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dvd, n_dvd;
    logic [W-1:0]  r_dsr, n_dsr;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    t_div_status   status;

    // shift in the next dividend bit and trial subtract
    assign shifted = {r_rem, r_dvd[W-1]};
    assign diff    = shifted - {1'b0, r_dsr};

    // sequencer of the shared subtractor
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            n_dvd = {r_dvd[W-2:0], 1'b0};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(W-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
    end

    assign status.busy = r_busy;
    assign status.done = r_done;
    assign o_status    = status;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// File: hdl/rotate_xor_string_hash_index.sv
// ----------------------------------------------------------------------------
// rotate_xor_string_hash_index
// rotating shift-xor string hash with bucket reduction modulo a nonzero table size
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one key byte per request
//   with i_byte_present and i_key_end. A request without key end updates
//   the running hash; the next byte may follow at once. A request with key
//   end starts the remainder: the iterative subtractor takes one quotient
//   bit per cycle; once the unit is done the block moves to its hold state,
//   loads the result into the output register when that register is free
//   and only then takes the next request. With a table size of zero the
//   bucket equals the raw hash and the request goes straight to the hold
//   state. o_in_ready is low until the result is loaded.
//   Output channel (o_out_valid / i_out_ready) holds bucket and raw hash in
//   a register; while the receiver stalls the block still takes key bytes,
//   and a finished remainder waits in the unit until the register frees.
//   Config channel (i_cfg_valid / o_cfg_ready) writes table_size, always
//   ready; write only while idle.
//   Reset (synchronous, active low) clears the running hash, drops any
//   pending result and sets table size to 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_xor_string_hash_index (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rxh_pkg::BYTE_W-1:0]  i_key_byte,
    input  logic                        i_byte_present,
    input  logic                        i_key_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rxh_pkg::HASH_W-1:0]  o_bucket_index,
    output logic [rxh_pkg::HASH_W-1:0]  o_raw_hash,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rxh_pkg::HASH_W-1:0]  i_cfg_data
);
    import rxh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [HASH_W-1:0]   r_final, n_final;
    logic                r_zero, n_zero;
    logic                r_out_valid, n_out_valid;
    logic [HASH_W-1:0]   r_bucket, n_bucket;
    logic [HASH_W-1:0]   r_raw, n_raw;
    logic [HASH_W-1:0]   r_table_size;

    logic                in_acc;
    logic                out_free;
    logic                div_start;
    logic [HASH_W-1:0]   mixed;
    logic [HASH_W-1:0]   remainder;
    t_div_status         div_status;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign mixed      = i_byte_present ? hash_mix(r_hash, i_key_byte) : r_hash;

    // shared remainder unit
    rxh_mod_unit #(
        .W (HASH_W)
    ) u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (mixed),
        .i_divisor   (r_table_size),
        .o_remainder (remainder),
        .o_status    (div_status)
    );

    // sequencer and output register loading
    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_final     = r_final;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        n_bucket    = r_bucket;
        n_raw       = r_raw;
        div_start   = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_key_end) begin
                        n_hash = mixed;
                    end else begin
                        n_hash  = '0;
                        n_final = mixed;
                        if (r_table_size == '0) begin
                            n_zero  = 1'b1;
                            n_state = S_HOLD;
                        end else begin
                            n_zero    = 1'b0;
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_status.done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_bucket    = r_zero ? r_final : remainder;
                    n_raw       = r_final;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_final  <= n_final;
        r_zero   <= n_zero;
        r_bucket <= n_bucket;
        r_raw    <= n_raw;
    end

    // table size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_table_size <= i_cfg_data;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_bucket_index = r_bucket;
    assign o_raw_hash     = r_raw;

endmodule

`default_nettype wire

// File: hdl/rxh_checker.sv
// ----------------------------------------------------------------------------
// rxh_checker
// port-level assertions for the hash index block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotate_xor_string_hash_index_defines.svh"

module rxh_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        i_key_end,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [rxh_pkg::HASH_W-1:0]  o_bucket_index,
    input  logic [rxh_pkg::HASH_W-1:0]  o_raw_hash
);
    logic in_acc;
    logic in_end;
    logic in_byte;
    logic out_stall;
    logic bucket_ok;

    assign in_acc    = i_in_valid && o_in_ready;
    assign in_end    = in_acc && i_key_end;
    assign in_byte   = in_acc && !i_key_end;
    assign out_stall = o_out_valid && !i_out_ready;
    assign bucket_ok = (o_bucket_index <= o_raw_hash);

    // a stalled result stays valid
    `RXH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid, "result dropped")

    // a key end request makes the block busy
    `RXH_ASSERT_NEXT(a_end_busy, i_clk, i_rst_n, in_end, !o_in_ready, "ready after key end")

    // a plain byte request leaves the block ready
    `RXH_ASSERT_NEXT(a_byte_ready, i_clk, i_rst_n, in_byte, o_in_ready, "busy after byte")

    // a remainder never exceeds its dividend
    `RXH_ASSERT_SAME(a_bucket_le_raw, i_clk, i_rst_n, o_out_valid, bucket_ok, "bucket above raw")

endmodule

bind rotate_xor_string_hash_index rxh_checker u_rxh_checker (.*);

`default_nettype wire

// File: dv/rotate_xor_string_hash_index_checker.sv
// ----------------------------------------------------------------------------
// rotate_xor_string_hash_index_checker
// watches the key, result and table size channels of the hash index block,
// keeps its own running hash and table size, queues the bucket and raw hash
// each key end should give, and compares every result request against them
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_xor_string_hash_index_checker
    import rxh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [BYTE_W-1:0]   i_key_byte,
    input  logic                i_byte_present,
    input  logic                i_key_end,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [HASH_W-1:0]   i_bucket_index,
    input  logic [HASH_W-1:0]   i_raw_hash,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [HASH_W-1:0]   i_cfg_data,
    input  logic                i_run_done,
    output int unsigned         o_pending_count,
    output int unsigned         o_error_count
);

    localparam int unsigned ROT_BITS    = 5;
    localparam int unsigned MAX_PRINTED = 60;

    typedef struct packed {
        logic [HASH_W-1:0] bucket;
        logic [HASH_W-1:0] raw;
    } bucket_result_t;

    bucket_result_t     expected_buckets[$];
    logic [HASH_W-1:0]  key_hash;
    logic [HASH_W-1:0]  table_size;
    logic               end_checked  = 1'b0;
    int unsigned        mismatches   = 0;

    assign o_error_count = mismatches;

    // rotate the hash left and fold one byte into the low bits
    function automatic logic [HASH_W-1:0] fold_key_byte(input logic [HASH_W-1:0] h,
                                                        input logic [BYTE_W-1:0] b);
        return ((h << ROT_BITS) | (h >> (HASH_W - ROT_BITS))) ^ HASH_W'(b);
    endfunction

    // one line per failure, quiet once the log has enough of them
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // predict on key requests, compare on result requests
    always @(posedge i_clk) begin
        bucket_result_t    want;
        logic [HASH_W-1:0] h;
        if (!i_rst_n) begin
            key_hash   = '0;
            table_size = TABLE_SIZE_RESET;
            expected_buckets.delete();
        end else begin
            // result request against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_buckets.size() == 0) begin
                    report_mismatch($sformatf("unexpected result bucket %h raw %h",
                                              i_bucket_index, i_raw_hash));
                end else begin
                    want = expected_buckets.pop_front();
                    if (i_bucket_index !== want.bucket) begin
                        report_mismatch($sformatf("bucket_index %h, expected %h",
                                                  i_bucket_index, want.bucket));
                    end
                    if (i_raw_hash !== want.raw) begin
                        report_mismatch($sformatf("raw_hash %h, expected %h",
                                                  i_raw_hash, want.raw));
                    end
                end
            end

            // table size write
            if (i_cfg_valid && i_cfg_ready) begin
                table_size = i_cfg_data;
            end

            // key request
            if (i_in_valid && i_in_ready) begin
                h = key_hash;
                if (i_byte_present) begin
                    h = fold_key_byte(h, i_key_byte);
                end
                if (i_key_end) begin
                    // a zero table size leaves the hash unreduced
                    want.raw    = h;
                    want.bucket = (table_size != '0) ? (h % table_size) : h;
                    expected_buckets.push_back(want);
                    key_hash = '0;
                end else begin
                    key_hash = h;
                end
            end

            // anything still queued once stimulus is over never came out
            if (i_run_done && !end_checked) begin
                end_checked = 1'b1;
                if (expected_buckets.size() != 0) begin
                    report_mismatch($sformatf("%0d results never arrived",
                                              expected_buckets.size()));
                end
            end
        end
        o_pending_count <= expected_buckets.size();
    end

endmodule

`default_nettype wire

// File: dv/rotate_xor_string_hash_index_tb.sv
// ----------------------------------------------------------------------------
// rotate_xor_string_hash_index_tb
// drives keys byte by byte into the hash index block in random bursts, with
// a receiver that stalls on changing patterns, and steps the table size
// through extremes and odd and random sizes between phases; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_xor_string_hash_index_tb;

    import rxh_pkg::*;

    localparam int unsigned RESET_CYCLES     = 5;
    localparam int unsigned DRAIN_CYCLES     = 48;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned ITEMS_PER_PHASE  = 155;
    localparam int unsigned SIZE_PHASES      = 8;

    typedef enum {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_BURSTY} recv_mode_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [BYTE_W-1:0]  i_key_byte;
    logic               i_byte_present;
    logic               i_key_end;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [HASH_W-1:0]  o_bucket_index;
    logic [HASH_W-1:0]  o_raw_hash;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [HASH_W-1:0]  i_cfg_data;
    logic               run_done;
    int unsigned        pending_results;
    int unsigned        error_count;

    int unsigned        burst_left  = 1;
    int unsigned        burst_max   = 40;
    int unsigned        idle_cycles = 0;
    int unsigned        recv_cycle  = 0;
    int unsigned        stall_left  = 0;
    recv_mode_t         recv_mode   = RX_ALWAYS;

    rotate_xor_string_hash_index u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_key_byte     (i_key_byte),
        .i_byte_present (i_byte_present),
        .i_key_end      (i_key_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bucket_index (o_bucket_index),
        .o_raw_hash     (o_raw_hash),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    rotate_xor_string_hash_index_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_key_byte      (i_key_byte),
        .i_byte_present  (i_byte_present),
        .i_key_end       (i_key_end),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_bucket_index  (o_bucket_index),
        .i_raw_hash      (o_raw_hash),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_run_done      (run_done),
        .o_pending_count (pending_results),
        .o_error_count   (error_count)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver: ready follows a stall pattern that is redrawn at random
    always @(posedge i_clk) begin
        recv_cycle++;
        if (recv_cycle % 256 == 0) begin
            recv_mode = recv_mode_t'($urandom_range(0, 3));
        end
        case (recv_mode)
            RX_ALWAYS:   i_out_ready <= 1'b1;
            RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_out_ready <= ((recv_cycle % 8) < 3);
            default: begin
                if (stall_left != 0) begin
                    i_out_ready <= 1'b0;
                    stall_left--;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) begin
                        stall_left = $urandom_range(1, 20);
                    end
                end
            end
        endcase
    end

    // watchdog: too long without any request moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one key request, then a random gap when the current burst runs out
    task automatic send_key_item(input logic [BYTE_W-1:0] b, input logic present,
                                 input logic last);
        i_in_valid     <= 1'b1;
        i_key_byte     <= b;
        i_byte_present <= present;
        i_key_end      <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = $urandom_range(1, burst_max);
        end
    endtask

    // random keys, mostly well formed, with stray and open-ended items mixed in
    task automatic send_random_keys(input int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int unsigned k;
        logic        open_end;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                // stray item, ignored by the block
                send_key_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else if (kind < 12) begin
                // empty key
                send_key_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
                sent++;
            end else begin
                len      = (kind < 92) ? $urandom_range(1, 10) : $urandom_range(11, 24);
                open_end = ($urandom_range(0, 6) == 0);
                for (k = 1; k <= len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_key_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
                    end
                    send_key_item(BYTE_W'($urandom_range(0, 255)), 1'b1,
                                  (k == len) && !open_end);
                    sent++;
                end
                // key closed by an item with no byte
                if (open_end) begin
                    send_key_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
                    sent++;
                end
            end
        end
    endtask

    // wait until every expected result is out and the remainder unit is idle
    task automatic wait_for_drain();
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [HASH_W-1:0] value);
        i_in_valid <= 1'b0;
        wait_for_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        int unsigned       phase;
        logic [HASH_W-1:0] size_sel;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_key_byte     <= '0;
        i_byte_present <= 1'b0;
        i_key_end      <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        run_done       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed keys under the reset table size
        send_key_item(8'hFF, 1'b0, 1'b1);       // empty key, byte field ignored
        send_key_item(8'h00, 1'b1, 1'b1);
        send_key_item(8'hFF, 1'b1, 1'b1);
        send_key_item(8'hA5, 1'b0, 1'b0);       // stray item, no effect
        send_key_item(8'h80, 1'b1, 1'b0);
        send_key_item(8'h3C, 1'b0, 1'b1);       // key closed without a byte
        repeat (7) send_key_item(8'hFF, 1'b1, 1'b0);
        send_key_item(8'hFF, 1'b1, 1'b1);       // high bits wrap around
        send_key_item(8'h01, 1'b1, 1'b0);
        send_key_item(8'h5A, 1'b0, 1'b0);       // stray item inside a key
        send_key_item(8'h02, 1'b1, 1'b0);
        send_key_item(8'hAA, 1'b1, 1'b0);
        send_key_item(8'h55, 1'b1, 1'b1);
        send_random_keys(ITEMS_PER_PHASE);

        // table size sweep: extremes, zero, odd and random sizes
        for (phase = 0; phase < SIZE_PHASES; phase++) begin
            case (phase)
                0:       size_sel = 32'd1;
                1:       size_sel = 32'd0;
                2:       size_sel = 32'hFFFF_FFFF;
                3:       size_sel = 32'h8000_0000;
                4:       size_sel = 32'd7;
                5:       size_sel = 32'd1_000_003;
                6:       size_sel = HASH_W'($urandom_range(2, 65535));
                default: size_sel = HASH_W'($urandom);
            endcase
            write_table_size(size_sel);
            burst_max  = (phase % 3 == 0) ? 1000 : 40;
            burst_left = $urandom_range(1, burst_max);
            send_random_keys(ITEMS_PER_PHASE);
        end

        i_in_valid <= 1'b0;
        wait_for_drain();
        run_done <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
